// ===== hw/rtl/ppks_pkg.sv =====
package ppks_pkg;

    // Keyframe table depth used when the top level is not told otherwise.
    localparam int MAX_FRAMES_DEF = 16;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd3;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int PHASE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int FCNT_W  = 5;
    localparam int FIDX_W  = 4;

    // Reset values of the registers.
    localparam logic [TIME_W-1:0]  PERIOD_RESET = 32'd65536;
    localparam logic [TIME_W-1:0]  START_RESET  = 32'd0;
    localparam logic [PHASE_W-1:0] SHIFT_RESET  = 16'd0;
    localparam logic [FCNT_W-1:0]  COUNT_RESET  = 5'd0;

    // Commands.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Start values of the step counters of the two division passes, counted down to zero.
    localparam logic [5:0] MOD_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS = 6'd15;

endpackage

// ===== hw/rtl/periodic_phase_keyframe_sequencer_core.sv =====
// Periodic phase keyframe sequencer.
// Items enter on start/busy: an item is taken at a rising edge where start is high and busy
// is low. A write command stores one keyframe entry in that cycle, gives no word back and
// leaves busy low. A tick command raises busy and, once finished, presents one result word
// on target_angle, selected_frame, cycle_phase, wrapped and angle_valid for a single cycle
// with done high; the receiver must take it in that cycle, as nothing holds it.
// A tick runs on one shared 33-bit subtract and compare unit: 33 steps reduce the sum of
// the accumulator and timestep modulo the period, 16 more produce the phase, then, when
// keyframes are in use, the keyframe tables are read one entry a cycle through a registered
// read port, comparing table entries after the starting frame (at most the frames in use
// minus one).
// busy falls in the cycle done is high, so the next item may be taken then.
// Registers sit on an APB-style port at byte addresses 0, 4, 8 and 12; writing the period or
// start time reloads the accumulator. Users write registers only while idle (not enforced).
// Reset clears the registers to their defaults, the accumulator and the previous frame;
// the keyframe tables keep no reset value and must be written before they are used.
module periodic_phase_keyframe_sequencer_core #(
    parameter int MAX_FRAMES = ppks_pkg::MAX_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [ppks_pkg::TIME_W-1:0]     timestep,
    input  logic [ppks_pkg::FIDX_W-1:0]     frame_index,
    input  logic [ppks_pkg::PHASE_W-1:0]    frame_start,
    input  logic signed [ppks_pkg::ANGLE_W-1:0] frame_angle,
    // result channel
    output logic                            done,
    output logic signed [ppks_pkg::ANGLE_W-1:0] target_angle,
    output logic [ppks_pkg::FIDX_W-1:0]     selected_frame,
    output logic [ppks_pkg::PHASE_W-1:0]    cycle_phase,
    output logic                            wrapped,
    output logic                            angle_valid,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppks_pkg::ADDR_W-1:0]     paddr,
    input  logic [ppks_pkg::DATA_W-1:0]     pwdata,
    output logic [ppks_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CW1   = CNT_W + 1;
    localparam int TW    = ppks_pkg::TIME_W;
    localparam int PW    = ppks_pkg::PHASE_W;
    localparam int AW    = ppks_pkg::ANGLE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FIRST = 3'd3;
    localparam logic [2:0] S_CHK0  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_ANG   = 3'd6;

    // Configuration registers.
    logic [TW-1:0]               period_reg;
    logic [TW-1:0]               start_time_reg;
    logic [PW-1:0]               shift_reg;
    logic [ppks_pkg::FCNT_W-1:0] count_reg;

    // Sequencer and datapath registers.
    logic [2:0]       state_reg, state_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [TW:0]      div_reg, div_next;
    logic             wrap_reg, wrap_next;
    logic [PW-1:0]    phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [TW-1:0]    acc_reg, acc_next;

    // Result registers.
    logic                       done_reg, done_next;
    logic [AW-1:0]              angle_out_reg, angle_out_next;
    logic [ppks_pkg::FIDX_W-1:0] sel_out_reg, sel_out_next;
    logic [PW-1:0]              phase_out_reg, phase_out_next;
    logic                       wrap_out_reg, wrap_out_next;
    logic                       valid_out_reg, valid_out_next;

    // Keyframe tables with a registered read port.
    logic [PW-1:0]    start_mem [MAX_FRAMES];
    logic [AW-1:0]    angle_mem [MAX_FRAMES];
    logic [PW-1:0]    rd_start_reg;
    logic [AW-1:0]    rd_angle_reg;
    logic [IDX_W-1:0] rd_addr;

    logic                          cfg_wr;
    logic [ppks_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [TW-1:0]                 cfg_p;
    logic [TW-1:0]                 cfg_s;
    logic                          tick_acc;
    logic                          write_acc;
    logic [TW-1:0]                 period_eff;
    logic [CNT_W-1:0]              n_w;
    logic [CW1-1:0]                n_x;
    logic [IDX_W-1:0]              idx_init;
    logic [IDX_W-1:0]              base_idx;
    logic [IDX_W-1:0]              nx_idx;

    // Shared subtract and compare unit.
    logic [TW:0]   sub_op;
    logic [TW+1:0] sub_diff;
    logic          sub_ge;
    logic [TW-1:0] sub_rem;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];
    assign tick_acc  = start && !busy && (command == ppks_pkg::CMD_TICK);
    assign write_acc = start && !busy && (command == ppks_pkg::CMD_WRITE);
    assign busy      = (state_reg != S_IDLE);

    assign period_eff = (period_reg == '0) ? TW'(1) : period_reg;
    assign n_w = (32'(count_reg) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(count_reg);
    assign n_x = CW1'(n_w);
    assign idx_init = (CNT_W'(prev_reg) < n_w) ? prev_reg : '0;

    assign sub_op   = {rem_reg, (state_reg == S_MOD) ? div_reg[TW] : 1'b0};
    assign sub_diff = {1'b0, sub_op} - {2'b00, period_eff};
    assign sub_ge   = !sub_diff[TW+1];
    assign sub_rem  = sub_ge ? sub_diff[TW-1:0] : sub_op[TW-1:0];

    always_comb
    begin
        cfg_p = period_reg;
        cfg_s = start_time_reg;
        if (cfg_idx == ppks_pkg::REG_PERIOD)
        begin
            cfg_p = pwdata;
        end
        if (cfg_idx == ppks_pkg::REG_START)
        begin
            cfg_s = pwdata;
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            ppks_pkg::REG_PERIOD: prdata = period_reg;
            ppks_pkg::REG_START:  prdata = start_time_reg;
            ppks_pkg::REG_SHIFT:  prdata = {{(ppks_pkg::DATA_W-PW){1'b0}}, shift_reg};
            ppks_pkg::REG_COUNT:
                prdata = {{(ppks_pkg::DATA_W-ppks_pkg::FCNT_W){1'b0}}, count_reg};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        wrap_next      = wrap_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        acc_next       = acc_reg;
        done_next      = 1'b0;
        angle_out_next = angle_out_reg;
        sel_out_next   = sel_out_reg;
        phase_out_next = phase_out_reg;
        wrap_out_next  = wrap_out_reg;
        valid_out_next = valid_out_reg;
        rd_addr        = idx_reg;
        base_idx       = idx_reg;
        nx_idx         = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_acc)
                begin
                    div_next   = {1'b0, acc_reg} + {1'b0, timestep};
                    rem_next   = '0;
                    wrap_next  = 1'b0;
                    cnt_next   = ppks_pkg::MOD_STEPS;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                // One quotient bit a cycle; any set bit means the sum reached the period.
                rem_next  = sub_rem;
                div_next  = {div_reg[TW-1:0], 1'b0};
                wrap_next = wrap_reg | sub_ge;
                if (cnt_reg == '0)
                begin
                    acc_next   = sub_rem;
                    cnt_next   = ppks_pkg::DIV_STEPS;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            S_DIV:
            begin
                // The phase quotient bits are shifted into the bottom of div_reg.
                rem_next = sub_rem;
                div_next = {div_reg[TW-1:0], sub_ge};
                if (cnt_reg == '0)
                begin
                    phase_next = div_next[PW-1:0] + shift_reg;
                    state_next = S_FIRST;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            S_FIRST:
            begin
                if (n_w == '0)
                begin
                    done_next      = 1'b1;
                    angle_out_next = '0;
                    sel_out_next   = '0;
                    phase_out_next = phase_reg;
                    wrap_out_next  = wrap_reg;
                    valid_out_next = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_init;
                    rd_addr    = idx_init;
                    state_next = S_CHK0;
                end
            end
            S_CHK0:
            begin
                // The search restarts at frame zero when the phase lies before the old frame.
                base_idx = (phase_reg < rd_start_reg) ? '0 : idx_reg;
                idx_next = base_idx;
                if ((CW1'(base_idx) + CW1'(1)) < n_x)
                begin
                    rd_addr    = base_idx + IDX_W'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    rd_addr    = base_idx;
                    state_next = S_ANG;
                end
            end
            S_SCAN:
            begin
                if (phase_reg >= rd_start_reg)
                begin
                    nx_idx   = idx_reg + IDX_W'(1);
                    idx_next = nx_idx;
                    if ((CW1'(nx_idx) + CW1'(1)) < n_x)
                    begin
                        rd_addr = nx_idx + IDX_W'(1);
                    end
                    else
                    begin
                        rd_addr    = nx_idx;
                        state_next = S_ANG;
                    end
                end
                else
                begin
                    rd_addr    = idx_reg;
                    state_next = S_ANG;
                end
            end
            S_ANG:
            begin
                done_next      = 1'b1;
                angle_out_next = rd_angle_reg;
                sel_out_next   = ppks_pkg::FIDX_W'(idx_reg);
                phase_out_next = phase_reg;
                wrap_out_next  = wrap_reg;
                valid_out_next = 1'b1;
                prev_next      = idx_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Writing the period or the start time reloads the accumulator.
        if (cfg_wr && ((cfg_idx == ppks_pkg::REG_PERIOD) || (cfg_idx == ppks_pkg::REG_START)))
        begin
            acc_next = (cfg_s < cfg_p) ? cfg_s : cfg_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= ppks_pkg::PERIOD_RESET;
            start_time_reg <= ppks_pkg::START_RESET;
            shift_reg      <= ppks_pkg::SHIFT_RESET;
            count_reg      <= ppks_pkg::COUNT_RESET;
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            prev_reg       <= '0;
            acc_reg        <= (ppks_pkg::START_RESET < ppks_pkg::PERIOD_RESET)
                              ? ppks_pkg::START_RESET : ppks_pkg::PERIOD_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    ppks_pkg::REG_PERIOD: period_reg     <= pwdata;
                    ppks_pkg::REG_START:  start_time_reg <= pwdata;
                    ppks_pkg::REG_SHIFT:  shift_reg      <= pwdata[PW-1:0];
                    ppks_pkg::REG_COUNT:  count_reg      <= pwdata[ppks_pkg::FCNT_W-1:0];
                endcase
            end
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        wrap_reg      <= wrap_next;
        phase_reg     <= phase_next;
        idx_reg       <= idx_next;
        angle_out_reg <= angle_out_next;
        sel_out_reg   <= sel_out_next;
        phase_out_reg <= phase_out_next;
        wrap_out_reg  <= wrap_out_next;
        valid_out_reg <= valid_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (write_acc && (32'(frame_index) < MAX_FRAMES))
        begin
            start_mem[IDX_W'(frame_index)] <= frame_start;
            angle_mem[IDX_W'(frame_index)] <= frame_angle;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_angle_reg <= angle_mem[rd_addr];
    end

    assign done           = done_reg;
    assign target_angle   = $signed(angle_out_reg);
    assign selected_frame = sel_out_reg;
    assign cycle_phase    = phase_out_reg;
    assign wrapped        = wrap_out_reg;
    assign angle_valid    = valid_out_reg;

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result word shown while the sequencer is still working");

    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == ppks_pkg::CMD_TICK)) |=> busy)
        else $error("accepted tick did not start the sequencer");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == ppks_pkg::CMD_WRITE)) |=> !done)
        else $error("keyframe write produced a result word");

    a_valid_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done && angle_valid) |-> ($past(state_reg) == S_ANG))
        else $error("valid angle emitted without a table lookup");

endmodule
